@@ design/bmmmv_pkg.sv @@
// Shared types, widths and helpers for the batch score statistics block.
package bmmmv_pkg;

    localparam longint MAX_ITEMS       = 128;
    localparam longint SCORE_TOP       = 1000;
    localparam longint THRESHOLD_RESET = 700;
    localparam longint HALF_SPAN_SQ    = (SCORE_TOP / 2) * (SCORE_TOP / 2);

    localparam int SCORE_W = 10;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W   = $clog2(MAX_ITEMS * SCORE_TOP + 1);
    localparam int SQS_W   = $clog2(MAX_ITEMS * SCORE_TOP * SCORE_TOP + 1);

    // Output field widths are fixed by the interface.
    localparam int CNT_OUT_W = 8;
    localparam int VAR_W     = 18;
    localparam int STD_W     = 9;

    // Back end arithmetic widths.
    localparam int PROD_A_W   = CNT_W + SQS_W;
    localparam int PROD_B_W   = 2 * SUM_W;
    localparam int N2_W       = 2 * CNT_W;
    localparam int NUM_W      = $clog2(MAX_ITEMS * MAX_ITEMS * HALF_SPAN_SQ + 1);
    localparam int RAD_W      = 2 * ((NUM_W + 3) / 2);
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS);
    localparam int DVD_W      = NUM_W + 1;
    localparam int DVS_W      = N2_W + 1;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SUM_W-1:0]   sum;
        logic [SQS_W-1:0]   sq_sum;
        logic [SCORE_W-1:0] max_score;
        logic [SCORE_W-1:0] min_score;
        logic [CNT_W-1:0]   above;
        logic [CNT_W-1:0]   below;
        logic [CNT_W-1:0]   equal;
    } t_batch;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] item_count;
        logic [SCORE_W-1:0]   max_score;
        logic [SCORE_W-1:0]   min_score;
        logic [SCORE_W-1:0]   mean_score;
        logic [CNT_OUT_W-1:0] above_count;
        logic [CNT_OUT_W-1:0] below_count;
        logic [CNT_OUT_W-1:0] equal_count;
        logic [VAR_W-1:0]     variance;
        logic [STD_W-1:0]     std_dev;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT,
        S_STD_GO,
        S_STD_WAIT
    } t_back_state;

    function automatic t_batch clear_batch();
        t_batch b;
        b           = '0;
        b.min_score = SCORE_W'(SCORE_TOP);
        return b;
    endfunction

endpackage

@@ design/bmmmv_front.sv @@
// Front end: threshold register and per-batch accumulation, one score per cycle while i_accept is high.
module bmmmv_front import bmmmv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCORE_W-1:0] i_cfg_data,
    input  logic               i_accept,
    input  logic [SCORE_W-1:0] i_score,
    input  logic               i_last_item,
    output logic               o_push,
    output t_batch             o_push_data
);

    logic [SCORE_W-1:0] r_threshold;
    t_batch             r_acc;
    t_batch             n_acc;
    t_batch             upd;
    logic [SCORE_W-1:0] score_sat;
    logic [2*SCORE_W-1:0] score_sq;

    assign score_sat = (i_score > SCORE_W'(SCORE_TOP)) ? SCORE_W'(SCORE_TOP) : i_score;
    assign score_sq  = (2*SCORE_W)'(score_sat) * (2*SCORE_W)'(score_sat);

    always_comb begin
        upd = r_acc;
        // A full batch ignores further scores; the marked item still closes it.
        if (r_acc.count < CNT_W'(MAX_ITEMS)) begin
            upd.count  = r_acc.count + CNT_W'(1);
            upd.sum    = r_acc.sum + SUM_W'(score_sat);
            upd.sq_sum = r_acc.sq_sum + SQS_W'(score_sq);
            if (score_sat > r_acc.max_score) begin
                upd.max_score = score_sat;
            end
            if (score_sat < r_acc.min_score) begin
                upd.min_score = score_sat;
            end
            if (score_sat > r_threshold) begin
                upd.above = r_acc.above + CNT_W'(1);
            end else if (score_sat < r_threshold) begin
                upd.below = r_acc.below + CNT_W'(1);
            end else begin
                upd.equal = r_acc.equal + CNT_W'(1);
            end
        end

        n_acc  = r_acc;
        o_push = 1'b0;
        if (i_accept) begin
            n_acc = upd;
            if (i_last_item) begin
                o_push = 1'b1;
                n_acc  = clear_batch();
            end
        end
        o_push_data = upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= SCORE_W'(THRESHOLD_RESET);
            r_acc       <= clear_batch();
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            r_acc <= n_acc;
        end
    end

endmodule

@@ design/bmmmv_queue.sv @@
// Short queue of closed batch snapshots between the front and back ends.
module bmmmv_queue import bmmmv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_batch i_push_data,
    input  logic   i_pop,
    output t_batch o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_batch              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    logic                do_push;
    logic                do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ design/bmmmv_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the back end.
module bmmmv_div import bmmmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DVD_W-1:0]     r_work;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic                 n_busy;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 n_done;
    logic [DVD_W-1:0]     n_work;
    logic [DVS_W-1:0]     n_rem;
    logic [DVS_W-1:0]     n_dvs;
    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       diff;
    logic                 fits;

    assign shifted    = {r_rem, r_work[DVD_W-1]};
    assign diff       = shifted - {1'b0, r_dvs};
    assign fits       = (shifted >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_work;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_work = r_work;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DVD_W);
            n_work = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            n_work = {r_work[DVD_W-2:0], fits};
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

endmodule

@@ design/bmmmv_back.sv @@
// Back end: turns one closed batch into mean, variance and standard deviation.
module bmmmv_back import bmmmv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_batch           i_head,
    output logic             o_pop,
    output t_div_req         o_div_req,
    input  logic             i_div_done,
    input  logic [DVD_W-1:0] i_quotient,
    output logic             o_strobe,
    output t_result          o_result
);

    t_back_state         r_state;
    t_back_state         n_state;
    t_batch              r_batch;
    t_batch              n_batch;
    logic [PROD_A_W-1:0] r_prod_a;
    logic [PROD_A_W-1:0] n_prod_a;
    logic [PROD_B_W-1:0] r_prod_b;
    logic [PROD_B_W-1:0] n_prod_b;
    logic [N2_W-1:0]     r_n2;
    logic [N2_W-1:0]     n_n2;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    n_num;
    logic [SCORE_W-1:0]  r_mean;
    logic [SCORE_W-1:0]  n_mean;
    logic [VAR_W-1:0]    r_var;
    logic [VAR_W-1:0]    n_var;
    logic [RAD_W-1:0]    r_sq_v;
    logic [RAD_W-1:0]    n_sq_v;
    logic [RAD_W-1:0]    r_sq_root;
    logic [RAD_W-1:0]    n_sq_root;
    logic [RAD_W-1:0]    r_sq_bit;
    logic [RAD_W-1:0]    n_sq_bit;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_strobe;
    logic                n_strobe;
    t_result             r_out;
    t_result             n_out;
    logic [NUM_W-1:0]    diff_num;
    logic [RAD_W-1:0]    trial;

    assign diff_num = NUM_W'(r_prod_a - PROD_A_W'(r_prod_b));
    assign trial    = r_sq_root + r_sq_bit;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_comb begin
        n_state   = r_state;
        n_batch   = r_batch;
        n_prod_a  = r_prod_a;
        n_prod_b  = r_prod_b;
        n_n2      = r_n2;
        n_num     = r_num;
        n_mean    = r_mean;
        n_var     = r_var;
        n_sq_v    = r_sq_v;
        n_sq_root = r_sq_root;
        n_sq_bit  = r_sq_bit;
        n_step    = r_step;
        n_out     = r_out;
        n_strobe  = 1'b0;
        o_pop     = 1'b0;
        o_div_req = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_batch = i_head;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod_a = PROD_A_W'(r_batch.count) * PROD_A_W'(r_batch.sq_sum);
                n_prod_b = PROD_B_W'(r_batch.sum) * PROD_B_W'(r_batch.sum);
                n_n2     = N2_W'(r_batch.count) * N2_W'(r_batch.count);
                n_state  = S_SUB;
            end
            S_SUB: begin
                // n times the sum of squared deviations; the root works on four times it.
                n_num     = diff_num;
                n_sq_v    = {diff_num, 2'b00};
                n_sq_root = '0;
                n_sq_bit  = RAD_W'(1) << (RAD_W - 2);
                n_step    = '0;
                n_state   = S_MEAN_GO;
            end
            S_MEAN_GO: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DVD_W'({r_batch.sum, 1'b0}) + DVD_W'(r_batch.count);
                o_div_req.divisor  = DVS_W'({r_batch.count, 1'b0});
                n_state            = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_div_done) begin
                    n_mean  = i_quotient[SCORE_W-1:0];
                    n_state = S_VAR_GO;
                end
            end
            S_VAR_GO: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DVD_W'({r_num, 1'b0}) + DVD_W'(r_n2);
                o_div_req.divisor  = {r_n2, 1'b0};
                n_state            = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (i_div_done) begin
                    n_var   = i_quotient[VAR_W-1:0];
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_sq_v >= trial) begin
                    n_sq_v    = r_sq_v - trial;
                    n_sq_root = (r_sq_root >> 1) + r_sq_bit;
                end else begin
                    n_sq_root = r_sq_root >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                n_step   = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_STD_GO;
                end
            end
            S_STD_GO: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DVD_W'(r_sq_root[ROOT_W-1:0]) + DVD_W'(r_batch.count);
                o_div_req.divisor  = DVS_W'({r_batch.count, 1'b0});
                n_state            = S_STD_WAIT;
            end
            S_STD_WAIT: begin
                if (i_div_done) begin
                    n_out.item_count  = CNT_OUT_W'(r_batch.count);
                    n_out.max_score   = r_batch.max_score;
                    n_out.min_score   = r_batch.min_score;
                    n_out.mean_score  = r_mean;
                    n_out.above_count = CNT_OUT_W'(r_batch.above);
                    n_out.below_count = CNT_OUT_W'(r_batch.below);
                    n_out.equal_count = CNT_OUT_W'(r_batch.equal);
                    n_out.variance    = r_var;
                    n_out.std_dev     = i_quotient[STD_W-1:0];
                    n_strobe          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_batch   <= n_batch;
        r_prod_a  <= n_prod_a;
        r_prod_b  <= n_prod_b;
        r_n2      <= n_n2;
        r_num     <= n_num;
        r_mean    <= n_mean;
        r_var     <= n_var;
        r_sq_v    <= n_sq_v;
        r_sq_root <= n_sq_root;
        r_sq_bit  <= n_sq_bit;
        r_step    <= n_step;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

endmodule

@@ design/batch_min_max_mean_variance_top.sv @@
// Batch score statistics: accumulation front end, snapshot queue, arithmetic back end.
// Scores are taken one per cycle whenever busy is low; a score transfer completes at a
// clock edge with start high and busy low. The marked last score closes the batch and
// its totals go into a two-entry queue, so the next batch can start in the very next
// cycle unless that push fills the queue. The back end takes each batch in turn: it
// pops the batch and forms its products, then makes three passes through one shared
// bit-serial divider (mean, variance, standard deviation), with a 17-step square root
// before the last pass. The result appears on the o_ ports with o_strobe high for
// exactly one cycle, and cannot be held off. busy rises only while two closed batches
// wait in the queue. The threshold may be written at any time the block is idle.
module batch_min_max_mean_variance_top import bmmmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SCORE_W-1:0]   i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [SCORE_W-1:0]   i_score,
    input  logic                 i_last_item,
    output logic                 o_strobe,
    output logic [CNT_OUT_W-1:0] o_item_count,
    output logic [SCORE_W-1:0]   o_max_score,
    output logic [SCORE_W-1:0]   o_min_score,
    output logic [SCORE_W-1:0]   o_mean_score,
    output logic [CNT_OUT_W-1:0] o_above_count,
    output logic [CNT_OUT_W-1:0] o_below_count,
    output logic [CNT_OUT_W-1:0] o_equal_count,
    output logic [VAR_W-1:0]     o_variance,
    output logic [STD_W-1:0]     o_std_dev
);

    logic             accept;
    logic             push;
    t_batch           push_data;
    t_batch           head;
    logic             empty;
    logic             full;
    logic             pop;
    t_div_req         div_req;
    logic             div_done;
    logic [DVD_W-1:0] quotient;
    t_result          result;

    assign busy   = full;
    assign accept = start && !busy;

    bmmmv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_score     (i_score),
        .i_last_item (i_last_item),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bmmmv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty),
        .o_full      (full)
    );

    bmmmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    bmmmv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_div_req  (div_req),
        .i_div_done (div_done),
        .i_quotient (quotient),
        .o_strobe   (o_strobe),
        .o_result   (result)
    );

    assign o_item_count  = result.item_count;
    assign o_max_score   = result.max_score;
    assign o_min_score   = result.min_score;
    assign o_mean_score  = result.mean_score;
    assign o_above_count = result.above_count;
    assign o_below_count = result.below_count;
    assign o_equal_count = result.equal_count;
    assign o_variance    = result.variance;
    assign o_std_dev     = result.std_dev;

endmodule
